/* src/gbcd_pkg.sv */
// Shared types, widths and register codes for the gyro bias calibration unit.
package gbcd_pkg;

   localparam int COUNT_WIDTH   = 16;
   localparam int RATE_WIDTH    = 24;
   localparam int SUM_WIDTH     = RATE_WIDTH + COUNT_WIDTH;
   localparam int TIME_WIDTH    = 32;
   localparam int THR_WIDTH     = 23;
   localparam int CSR_IDX_WIDTH = 1;
   localparam int CSR_DAT_WIDTH = 32;
   localparam int REQ_DAT_WIDTH = 56;
   localparam int RSP_DAT_WIDTH = 24;
   localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH);

   localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(SUM_WIDTH - 1);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CALIB_DURATION     = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROTATION_THRESHOLD = 1'b1;

   localparam logic [TIME_WIDTH-1:0] CALIB_DURATION_RESET     = 32'd5000000;
   localparam logic [THR_WIDTH-1:0]  ROTATION_THRESHOLD_RESET = 23'd13107;

   // controller to datapath
   typedef struct packed {
      logic take;       // item accepted this cycle
      logic accum;      // add item to the window sum
      logic div_start;  // launch the bias division
      logic emit;       // load the result register
      logic use_held;   // emit from the held item instead of the input
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_window;  // item falls inside the averaging window
      logic out_free;   // result register can take a new item
      logic div_done;   // bias register loaded
   } status_type;

endpackage

/* src/gyro_bias_calibrate_and_detect_unit.sv */
// Top level of the gyro zero-rate bias calibration and rotation detection unit.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: timestamp_us[31:0], yaw_rate[55:32]
//   rsp      out        rsp_tvalid/rsp_tready  tdata: corrected_rate[23:0]; tuser: rotating
//   csr      in         csr_valid/csr_ready    csr_index, csr_data (0 duration, 1 threshold)
//
// An item inside the averaging window or after calibration is handled in the idle
// state. The item that closes the window goes through the 40-step shift-subtract
// bias divider, waits for its done flag and then loads the result register.
// Reset (synchronous, active high) clears sum, count, bias and flags and
// restores the register defaults. A stalled result holds in the output
// register; one more item is taken only once that register frees up.
module gyro_bias_calibrate_and_detect_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gbcd_pkg::REQ_DAT_WIDTH-1:0]    req_tdata,  // timestamp_us, yaw_rate
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gbcd_pkg::RSP_DAT_WIDTH-1:0]    rsp_tdata,  // corrected_rate
   output logic                                  rsp_tuser,  // rotating
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gbcd_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [gbcd_pkg::CSR_DAT_WIDTH-1:0]    csr_data
);
   import gbcd_pkg::*;

   cmd_type                      cmd;
   status_type                   status;
   logic signed [RATE_WIDTH-1:0] rsp_rate;

   // registers are always writable; writes must come only while idle, which the block does not enforce
   assign csr_ready = 1'b1;

   gbcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   gbcd_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_time     (req_tdata[TIME_WIDTH-1:0]),
      .req_rate     (req_tdata[TIME_WIDTH +: RATE_WIDTH]),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_taken    (rsp_tvalid && rsp_tready),
      .rsp_rate     (rsp_rate),
      .rsp_rotating (rsp_tuser)
   );

   assign rsp_tdata = rsp_rate;

endmodule

/* src/gbcd_div.sv */
// Shift-subtract signed-by-unsigned divider, one quotient bit per cycle.
module gbcd_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [gbcd_pkg::SUM_WIDTH-1:0]   dividend,
   input  logic        [gbcd_pkg::COUNT_WIDTH-1:0] divisor,
   output logic                                 done,
   output logic signed [gbcd_pkg::RATE_WIDTH-1:0]  quotient
);
   import gbcd_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [COUNT_WIDTH:0]     rem_ff, rem_in;
   logic [SUM_WIDTH-1:0]     quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]   dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic [COUNT_WIDTH:0]     rem_sh;
   logic                     fits;
   logic [RATE_WIDTH-1:0]    q_mag;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff[COUNT_WIDTH-1:0], quo_ff[SUM_WIDTH-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[SUM_WIDTH-1];
         quo_in  = dividend[SUM_WIDTH-1] ? SUM_WIDTH'(-dividend) : SUM_WIDTH'(dividend);
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_in = {quo_ff[SUM_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // empty window gives a zero bias
   assign q_mag    = quo_ff[RATE_WIDTH-1:0];
   assign done     = done_ff;
   assign quotient = (dvs_ff == '0) ? '0 : (neg_ff ? -q_mag : q_mag);

endmodule

/* src/gbcd_dpath.sv */
// Datapath: window timing, rate sum and count, bias, correction and result register.
module gbcd_dpath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  gbcd_pkg::cmd_type                       cmd,
   output gbcd_pkg::status_type                    status,
   input  logic [gbcd_pkg::TIME_WIDTH-1:0]         req_time,
   input  logic signed [gbcd_pkg::RATE_WIDTH-1:0]  req_rate,
   input  logic                                    csr_write,
   input  logic [gbcd_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [gbcd_pkg::CSR_DAT_WIDTH-1:0]      csr_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_taken,
   output logic signed [gbcd_pkg::RATE_WIDTH-1:0]  rsp_rate,
   output logic                                    rsp_rotating
);
   import gbcd_pkg::*;

   logic [TIME_WIDTH-1:0]         dur_ff;
   logic [THR_WIDTH-1:0]          thr_ff;
   logic                          started_ff;
   logic [TIME_WIDTH-1:0]         start_ff;
   logic signed [SUM_WIDTH-1:0]   sum_ff;
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic signed [RATE_WIDTH-1:0]  bias_ff;
   logic signed [RATE_WIDTH-1:0]  held_ff;
   logic                          valid_ff, valid_in;
   logic signed [RATE_WIDTH-1:0]  out_rate_ff;
   logic                          out_rot_ff;

   logic [TIME_WIDTH-1:0]         elapsed;
   logic signed [RATE_WIDTH-1:0]  src_rate;
   logic signed [RATE_WIDTH:0]    diff;
   logic signed [RATE_WIDTH-1:0]  corr;
   logic signed [RATE_WIDTH:0]    corr_x, thr_pos, thr_neg;
   logic                          rot;
   logic                          div_done;
   logic signed [RATE_WIDTH-1:0]  quotient;

   gbcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // first item starts the window at elapsed zero
   assign elapsed = started_ff ? (req_time - start_ff) : '0;

   always_comb begin
      src_rate = cmd.use_held ? held_ff : req_rate;
      diff     = {src_rate[RATE_WIDTH-1], src_rate} - {bias_ff[RATE_WIDTH-1], bias_ff};
      if (diff[RATE_WIDTH] != diff[RATE_WIDTH-1])
         corr = diff[RATE_WIDTH] ? {1'b1, {(RATE_WIDTH-1){1'b0}}}
                                 : {1'b0, {(RATE_WIDTH-1){1'b1}}};
      else
         corr = diff[RATE_WIDTH-1:0];
      corr_x  = {corr[RATE_WIDTH-1], corr};
      thr_pos = {2'b00, thr_ff};
      thr_neg = -thr_pos;
      rot     = (corr_x > thr_pos) || (corr_x < thr_neg);
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_taken)
         valid_in = 1'b0;
      if (cmd.emit)
         valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff     <= CALIB_DURATION_RESET;
         thr_ff     <= ROTATION_THRESHOLD_RESET;
         started_ff <= 1'b0;
         start_ff   <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         bias_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_CALIB_DURATION:     dur_ff <= csr_data;
               CSR_ROTATION_THRESHOLD: thr_ff <= csr_data[THR_WIDTH-1:0];
               default: ;
            endcase
         end
         if (cmd.take && !started_ff) begin
            started_ff <= 1'b1;
            start_ff   <= req_time;
         end
         // hold sum and count once the count saturates
         if (cmd.accum && (count_ff != '1)) begin
            sum_ff   <= sum_ff + {{COUNT_WIDTH{req_rate[RATE_WIDTH-1]}}, req_rate};
            count_ff <= count_ff + 1'b1;
         end
         if (div_done)
            bias_ff <= quotient;
         valid_ff <= valid_in;
      end
      if (cmd.take)
         held_ff <= req_rate;
      if (cmd.emit) begin
         out_rate_ff <= corr;
         out_rot_ff  <= rot;
      end
   end

   assign status.in_window = elapsed < dur_ff;
   assign status.out_free  = !valid_ff || rsp_taken;
   assign status.div_done  = div_done;

   assign rsp_valid    = valid_ff;
   assign rsp_rate     = out_rate_ff;
   assign rsp_rotating = out_rot_ff;

endmodule

/* src/gbcd_ctrl.sv */
// Controller: accept items, steer window accumulation, the bias division and result loads.
module gbcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gbcd_pkg::status_type status,
   output gbcd_pkg::cmd_type    cmd
);
   import gbcd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       calibrated_ff, calibrated_in;
   logic       take;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign take      = req_ready && req_valid;

   always_comb begin
      state_in      = state_ff;
      calibrated_in = calibrated_ff;
      cmd           = '0;
      cmd.take      = take;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (calibrated_ff) begin
                  cmd.emit = 1'b1;
               end else if (status.in_window) begin
                  cmd.accum = 1'b1;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               calibrated_in = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.use_held = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         calibrated_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         calibrated_ff <= calibrated_in;
      end
   end

endmodule

/* src/gbcd_chk.sv */
// Port-level checker for the gyro bias calibration unit, bound to the top level.
module gbcd_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [gbcd_pkg::RSP_DAT_WIDTH-1:0] rsp_tdata,
   input logic                               rsp_tuser
);
   import gbcd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while result register is blocked");

   a_rot_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata != '0)
      else $error("rotation flagged on zero corrected rate");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind gyro_bias_calibrate_and_detect_unit gbcd_chk u_gbcd_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
